// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/aspa_pkg.sv =====
package aspa_pkg;

    // fixed field widths of the transaction payloads
    localparam int NUM_W = 31;
    localparam int SUM_W = 34;

    // default for the number width parameter
    localparam int NUMBER_WIDTH_DEF = 31;

    // input transaction
    typedef struct packed {
        logic [NUM_W-1:0] value_a;
        logic [NUM_W-1:0] value_b;
    } in_t;

    // result transaction
    typedef struct packed {
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
        logic             a_is_perfect;
        logic             pair_is_amicable;
    } out_t;

    // status a lane hands to the top level
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } lane_status_t;

    // lane sequencer states
    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_CHECK,
        LANE_DIV,
        LANE_ACC,
        LANE_DONE
    } lane_state_t;

endpackage

// ===== rtl/aspa_lane.sv =====
module aspa_lane #(
    parameter int NUMBER_WIDTH = aspa_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] value,
    output aspa_pkg::lane_status_t  status
);
    import aspa_pkg::*;

    // trial divisor width: reaches floor(sqrt(x)) + 1
    localparam int DW    = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int DSQ_W = 2 * DW;
    localparam int CW    = $clog2(NUMBER_WIDTH);

    lane_state_t             state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] x_reg, x_next;
    logic [DW-1:0]           d_reg, d_next;
    logic [DSQ_W-1:0]        dsq_reg, dsq_next;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [NUMBER_WIDTH-1:0] quo_reg, quo_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [SUM_W-1:0]        total_reg, total_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;

    logic             too_big;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             fits;
    logic [SUM_W-1:0] addend;

    // divisor loop ends once d*d passes x
    assign too_big = dsq_reg > DSQ_W'(x_reg);

    // one restoring division step
    assign shifted = {rem_reg, x_reg[cnt_reg]};
    assign diff    = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};

    // divisor plus its partner, partner counted once for a square
    assign addend = SUM_W'(d_reg)
                  + ((NUMBER_WIDTH'(d_reg) != quo_reg) ? SUM_W'(quo_reg) : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LANE_IDLE, LANE_DONE:
            begin
                if (start)
                    state_next = LANE_CHECK;
            end
            LANE_CHECK:
            begin
                state_next = too_big ? LANE_DONE : LANE_DIV;
            end
            LANE_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = LANE_ACC;
            end
            LANE_ACC:
            begin
                state_next = LANE_CHECK;
            end
            default:
            begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        x_next     = x_reg;
        d_next     = d_reg;
        dsq_next   = dsq_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        sum_next   = sum_reg;
        case (state_reg)
            LANE_IDLE, LANE_DONE:
            begin
                if (start)
                begin
                    x_next     = value;
                    d_next     = DW'(1);
                    dsq_next   = DSQ_W'(1);
                    total_next = '0;
                end
            end
            LANE_CHECK:
            begin
                if (too_big)
                    sum_next = total_reg - SUM_W'(x_reg);
                else
                begin
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = CW'(NUMBER_WIDTH - 1);
                end
            end
            LANE_DIV:
            begin
                rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
                quo_next = {quo_reg[NUMBER_WIDTH-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
            end
            LANE_ACC:
            begin
                if (rem_reg == '0)
                    total_next = total_reg + addend;
                d_next   = d_reg + 1'b1;
                dsq_next = dsq_reg + DSQ_W'({d_reg, 1'b1});
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        status.done = (state_reg == LANE_DONE);
        status.sum  = sum_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LANE_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        d_reg     <= d_next;
        dsq_reg   <= dsq_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        sum_reg   <= sum_next;
    end

endmodule

// ===== rtl/aspa_merge.sv =====
module aspa_merge #(
    parameter int NUMBER_WIDTH = aspa_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       capture,
    input  logic [NUMBER_WIDTH-1:0]    value_a,
    input  logic [NUMBER_WIDTH-1:0]    value_b,
    input  logic [aspa_pkg::SUM_W-1:0] sum_a,
    input  logic [aspa_pkg::SUM_W-1:0] sum_b,
    output aspa_pkg::out_t             result,
    output logic                       result_valid
);
    import aspa_pkg::*;

    out_t result_reg, result_next;
    logic valid_reg;

    // combine the two lane sums into flags
    always_comb
    begin
        result_next.sum_a            = sum_a;
        result_next.sum_b            = sum_b;
        result_next.a_is_perfect     = (value_a > NUMBER_WIDTH'(1))
                                     && (sum_a == SUM_W'(value_a));
        result_next.pair_is_amicable = (sum_a == SUM_W'(value_b))
                                     && (sum_b == SUM_W'(value_a));
    end

    // strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= capture;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (capture)
            result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

// ===== rtl/aliquot_sum_perfect_amicable.sv =====
// Aliquot sum, perfect and amicable checker.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low; operands carries value_a and value_b, of which the low
// NUMBER_WIDTH bits are used. busy stays high until the result is formed.
// Result channel: result is valid for exactly one cycle while result_valid
// is high; the receiver cannot stall, so it must take it in that cycle.
// Two lanes work side by side, one per operand, each doing trial division by
// d = 1, 2, ... while d*d <= x, adding d and x/d for each divisor found.
// Each trial divisor passes through the lane's CHECK, DIV and ACC states, with
// the bit-serial restoring divider in DIV; a lane is done once d*d passes x.
// The result strobe comes in the cycle after the slower of the two lanes is
// done; a new transaction may start on the cycle the result strobe is shown.
// Reset: both lanes idle, busy low, no result strobe.
module aliquot_sum_perfect_amicable #(
    parameter int NUMBER_WIDTH = aspa_pkg::NUMBER_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  aspa_pkg::in_t operands,
    output aspa_pkg::out_t result,
    output logic          result_valid
);
    import aspa_pkg::*;

    `include "assert_macros.svh"

    logic                    busy_reg, busy_next;
    logic [NUMBER_WIDTH-1:0] a_reg, b_reg;
    logic                    accept;
    logic                    capture;
    lane_status_t            status_a, status_b;

    // transaction handshake
    assign accept  = start && !busy_reg;
    assign capture = busy_reg && status_a.done && status_b.done;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (capture)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // operands kept for the merge flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= operands.value_a[NUMBER_WIDTH-1:0];
            b_reg <= operands.value_b[NUMBER_WIDTH-1:0];
        end
    end

    // one lane per operand
    aspa_lane #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_lane_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (operands.value_a[NUMBER_WIDTH-1:0]),
        .status (status_a)
    );

    aspa_lane #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_lane_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (operands.value_b[NUMBER_WIDTH-1:0]),
        .status (status_b)
    );

    // combine lane results
    aspa_merge #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .capture      (capture),
        .value_a      (a_reg),
        .value_b      (b_reg),
        .sum_a        (status_a.sum),
        .sum_b        (status_b.sum),
        .result       (result),
        .result_valid (result_valid)
    );

    assign busy = busy_reg;

    // checks
    `ASSERT_NEXT(a_accept_sets_busy, clk, rst_n, accept, busy_reg)
    `ASSERT_IMPL(a_strobe_after_busy, clk, rst_n, result_valid, $past(busy_reg))
    `ASSERT_IMPL(a_strobe_frees_input, clk, rst_n, result_valid, !busy_reg)
    `ASSERT_NEXT(a_capture_strobes, clk, rst_n, capture, result_valid)

endmodule

// ===== tb/sv/aliquot_checker.sv =====
module aliquot_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  aspa_pkg::in_t  operands,
    input  aspa_pkg::out_t result,
    input  logic           result_valid,
    output int             mismatches,
    output int             in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import aspa_pkg::*;

    // results still owed by the block, oldest first
    out_t expected_sums[$];

    // proper divisor sum: pair each divisor d <= sqrt(x) with x/d, then drop x
    function automatic logic [SUM_W-1:0] aliquot_sum(input logic [NUM_W-1:0] x);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] total;
        n = 64'(x);
        total = '0;
        if (n <= 64'd1)
            return '0;
        for (d = 64'd1; d * d <= n; d++)
        begin
            if (n % d == 64'd0)
            begin
                total += d;
                if (n / d != d)
                    total += n / d;
            end
        end
        return SUM_W'(total - n);
    endfunction

    // full expected result of one transaction
    function automatic out_t divisor_report(input in_t pair);
        out_t rep;
        rep.sum_a = aliquot_sum(pair.value_a);
        rep.sum_b = aliquot_sum(pair.value_b);
        rep.a_is_perfect = (pair.value_a > 1) && (rep.sum_a == SUM_W'(pair.value_a));
        rep.pair_is_amicable = (rep.sum_a == SUM_W'(pair.value_b))
                               && (rep.sum_b == SUM_W'(pair.value_a));
        return rep;
    endfunction

    // one field compare with report
    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare results first, then queue the transaction accepted at this edge
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    check_field("sum_a", want.sum_a, result.sum_a);
                    check_field("sum_b", want.sum_b, result.sum_b);
                    check_field("a_is_perfect", SUM_W'(want.a_is_perfect),
                                SUM_W'(result.a_is_perfect));
                    check_field("pair_is_amicable", SUM_W'(want.pair_is_amicable),
                                SUM_W'(result.pair_is_amicable));
                end
            end
            if (start && !busy)
                expected_sums.push_back(divisor_report(operands));
            in_flight = expected_sums.size();
        end
    end

    // leftover expectations are reported when the run stops
    final
    begin
        if (expected_sums.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_sums.size());
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aspa_pkg::*;

    localparam int STALL_LIMIT = 8_000_000;
    localparam int RANDOM_PAIRS = 100;
    localparam int AMICABLE_COUNT = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  operands = '0;
    logic busy;
    out_t result;
    logic result_valid;
    int   mismatches;
    int   in_flight;
    int   idle_cycles = 0;
    int   burst_left = 0;

    // known amicable pairs, small enough to run quickly
    logic [NUM_W-1:0] amicable_lo [AMICABLE_COUNT] =
        '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296};
    logic [NUM_W-1:0] amicable_hi [AMICABLE_COUNT] =
        '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416};
    logic [NUM_W-1:0] perfect_nums [4] = '{6, 28, 496, 8128};

    aliquot_sum_perfect_amicable DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .result       (result),
        .result_valid (result_valid)
    );

    aliquot_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .result       (result),
        .result_valid (result_valid),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    always #10 clk = ~clk;

    // watchdog on cycles where no transaction moves either way
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // random number with a random bit length, kept short so trial division stays fast
    function automatic logic [NUM_W-1:0] short_number();
        int unsigned len;
        len = $urandom_range(1, 18);
        return NUM_W'($urandom & ((32'd1 << len) - 1));
    endfunction

    // offer one transaction, hold it until taken, then maybe pause between bursts
    task automatic send_pair(input logic [NUM_W-1:0] a, input logic [NUM_W-1:0] b);
        int unsigned gap;
        start <= 1'b1;
        operands <= '{value_a: a, value_b: b};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    initial
    begin
        int unsigned sel;
        int unsigned k;
        logic [NUM_W-1:0] x;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero and one, squares, perfect and amicable numbers, extremes
        send_pair(0, 0);
        send_pair(1, 1);
        send_pair(0, 1);
        send_pair(1, 0);
        send_pair(2, 3);
        send_pair(4, 9);
        send_pair(6, 6);
        send_pair(28, 28);
        send_pair(496, 8128);
        send_pair(8128, 6);
        send_pair(12, 12);
        send_pair(220, 284);
        send_pair(284, 220);
        send_pair(1184, 1210);
        send_pair(17296, 18416);
        send_pair(18416, 17296);
        send_pair(33550336, 0);
        send_pair(0, 1);
        send_pair({NUM_W{1'b1}}, {NUM_W{1'b1}});

        // random mix of plain numbers and rarer well-formed cases
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                k = $urandom_range(0, AMICABLE_COUNT - 1);
                if ($urandom_range(0, 1))
                    send_pair(amicable_lo[k], amicable_hi[k]);
                else
                    send_pair(amicable_hi[k], amicable_lo[k]);
            end
            else if (sel < 22)
            begin
                k = $urandom_range(0, 3);
                send_pair(perfect_nums[k],
                          $urandom_range(0, 1) ? perfect_nums[k] : short_number());
            end
            else if (sel < 32)
            begin
                x = short_number();
                send_pair(x, x);
            end
            else if (sel < 38)
                send_pair(NUM_W'($urandom_range(0, 1)), short_number());
            else
                send_pair(short_number(), short_number());
        end
        start <= 1'b0;

        // drain outstanding results, then give a spurious strobe time to show
        @(negedge clk);
        while (in_flight != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
